>>> rtl/contour_slope_angle_sum_defines.svh
// Assertion macros for the contour slope-angle sum checker.
// No dependencies; included by the checker file only.
`ifndef CONTOUR_SLOPE_ANGLE_SUM_DEFINES_SVH
`define CONTOUR_SLOPE_ANGLE_SUM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CSAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CSAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/csas_pkg.sv
// Package for the contour slope-angle sum block: payload types, defaults,
// the CORDIC arctangent table and the angle rounding helper. No dependencies.
`timescale 1ns / 1ps

package csas_pkg;

  localparam int MaxPointsDef     = 4096;
  localparam int AngleFracBitsDef = 12;
  localparam int CountOutW        = 13;
  localparam int SumW             = 26;
  localparam int ZW               = 34;
  localparam int XyW              = 33;

  typedef struct packed {
    logic [14:0] point_x;
    logic [14:0] point_y;
    logic        last_point;
  } csas_in_t;

  typedef struct packed {
    logic signed [SumW-1:0] angle_sum;
    logic                   undefined_term;
    logic [CountOutW-1:0]   point_count;
  } csas_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture_first;
    logic capture_next;
    logic load_pair;
    logic close_sel;
    logic iter_step;
    logic accum;
    logic emit;
  } csas_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic iter_last;
  } csas_sts_t;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      5'd11:   v = 34'sd524288;
      5'd12:   v = 34'sd262144;
      5'd13:   v = 34'sd131072;
      5'd14:   v = 34'sd65536;
      5'd15:   v = 34'sd32768;
      5'd16:   v = 34'sd16384;
      5'd17:   v = 34'sd8192;
      5'd18:   v = 34'sd4096;
      5'd19:   v = 34'sd2048;
      5'd20:   v = 34'sd1024;
      5'd21:   v = 34'sd512;
      5'd22:   v = 34'sd256;
      5'd23:   v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up from 30 fraction bits down to 30 - s fraction bits
  function automatic logic signed [SumW-1:0] round_angle(input logic signed [ZW-1:0] z,
                                                         input int unsigned s);
    logic signed [ZW-1:0] biased;
    logic signed [ZW-1:0] shifted;
    biased  = z + (34'sd1 <<< (s - 1));
    shifted = biased >>> s;
    return shifted[SumW-1:0];
  endfunction

endpackage

>>> rtl/csas_dp.sv
// Datapath: point registers, iterative vectoring CORDIC, saturating
// accumulator and the result register. Depends on csas_pkg.
`timescale 1ns / 1ps

module csas_dp import csas_pkg::*; #(
  parameter int MAX_POINTS      = MaxPointsDef,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  csas_in_t  in_data,
  input  csas_cmd_t cmd,
  output csas_sts_t sts,
  output csas_out_t out_data
);

  localparam int Iters    = ANGLE_FRAC_BITS + 4;
  localparam int IterW    = $clog2(Iters);
  localparam int CntW     = $clog2(MAX_POINTS + 1);
  localparam int RndShift = 30 - ANGLE_FRAC_BITS;

  // Point registers
  logic [14:0] first_x_r, first_y_r, prev_x_r, prev_y_r, cur_x_r, cur_y_r;

  // CORDIC state
  logic signed [XyW-1:0] x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  logic [IterW-1:0]      iter_r;
  logic                  neg_r, dy_neg_r, vert_r, zero_r;

  // Accumulation state
  logic signed [SumW-1:0] sum_r;
  logic [CntW-1:0]        count_r;
  logic                   undef_r;
  csas_out_t              out_r;

  // Pair select and differences
  logic [14:0]        ax, ay, bx, by;
  logic signed [15:0] dx, dy, adx, ady;

  assign ax  = cmd.close_sel ? cur_x_r   : prev_x_r;
  assign ay  = cmd.close_sel ? cur_y_r   : prev_y_r;
  assign bx  = cmd.close_sel ? first_x_r : cur_x_r;
  assign by  = cmd.close_sel ? first_y_r : cur_y_r;
  assign dx  = $signed({1'b0, bx}) - $signed({1'b0, ax});
  assign dy  = $signed({1'b0, by}) - $signed({1'b0, ay});
  assign adx = dx[15] ? -dx : dx;
  assign ady = dy[15] ? -dy : dy;

  // One CORDIC rotation
  logic signed [XyW-1:0] xs, ys;
  logic signed [ZW-1:0]  atan_i;

  assign xs     = x_r >>> iter_r;
  assign ys     = y_r >>> iter_r;
  assign atan_i = atan_val(5'(iter_r));

  // Term select and saturating add
  logic signed [SumW-1:0] cordic_t, vert_t, term;
  logic signed [SumW:0]   sum_ext;
  logic signed [SumW-1:0] sum_sat;

  assign cordic_t = round_angle(z_r, RndShift);
  assign vert_t   = round_angle(atan_val(5'd0) <<< 1, RndShift);

  always_comb begin
    if (zero_r) begin
      term = '0;
    end else if (vert_r) begin
      term = dy_neg_r ? -vert_t : vert_t;
    end else begin
      term = neg_r ? -cordic_t : cordic_t;
    end
    sum_ext = {sum_r[SumW-1], sum_r} + {term[SumW-1], term};
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_sat = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SumW-1:0];
    end
  end

  // Point capture
  always_ff @(posedge clk) begin
    if (cmd.capture_first) begin
      first_x_r <= in_data.point_x;
      first_y_r <= in_data.point_y;
      prev_x_r  <= in_data.point_x;
      prev_y_r  <= in_data.point_y;
    end else if (cmd.accum && !cmd.close_sel) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end
    if (cmd.capture_first || cmd.capture_next) begin
      cur_x_r <= in_data.point_x;
      cur_y_r <= in_data.point_y;
    end
  end

  // CORDIC load and iterate
  always_ff @(posedge clk) begin
    if (cmd.load_pair) begin
      x_r      <= $signed({3'b000, adx[14:0], 15'd0});
      y_r      <= $signed({3'b000, ady[14:0], 15'd0});
      z_r      <= '0;
      iter_r   <= '0;
      neg_r    <= dx[15] ^ dy[15];
      dy_neg_r <= dy[15];
      vert_r   <= (dx == 16'sd0);
      zero_r   <= (dx == 16'sd0) && (dy == 16'sd0);
    end else if (cmd.iter_step) begin
      if (!y_r[XyW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_i;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_i;
      end
      iter_r <= iter_r + 1'b1;
    end
  end

  // Accumulator, counter, sticky flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      undef_r <= 1'b0;
    end else if (cmd.emit) begin
      sum_r   <= '0;
      count_r <= '0;
      undef_r <= 1'b0;
    end else begin
      if ((cmd.capture_first || cmd.capture_next) && (count_r < CntW'(MAX_POINTS))) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.accum) begin
        sum_r <= sum_sat;
        if (zero_r) begin
          undef_r <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.angle_sum      <= sum_r;
      out_r.undefined_term <= undef_r;
      out_r.point_count    <= CountOutW'(count_r);
    end
  end

  assign out_data       = out_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.iter_last  = (iter_r == IterW'(Iters - 1));

endmodule

>>> rtl/csas_ctrl.sv
// Controller: sequences capture, CORDIC passes, accumulation and result
// hand-off, and owns the channel handshakes. Depends on csas_pkg.
`timescale 1ns / 1ps

module csas_ctrl import csas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  csas_sts_t sts,
  output csas_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ITER,
    S_ACC,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   close_r, last_r, out_valid_r;
  logic   accept, emit_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // Decode commands from state
  always_comb begin
    cmd               = '0;
    cmd.capture_first = accept && sts.count_zero;
    cmd.capture_next  = accept && !sts.count_zero;
    cmd.load_pair     = (state_r == S_LOAD);
    cmd.close_sel     = close_r;
    cmd.iter_step     = (state_r == S_ITER);
    cmd.accum         = (state_r == S_ACC);
    cmd.emit          = emit_fire;
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      close_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            last_r  <= in_last;
            close_r <= 1'b0;
            if (sts.count_zero) begin
              state_r <= in_last ? S_EMIT : S_IDLE;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state_r <= S_ITER;
        end
        S_ITER: begin
          if (sts.iter_last) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (close_r) begin
            state_r <= S_EMIT;
          end else if (last_r) begin
            close_r <= 1'b1;
            state_r <= S_LOAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            close_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/contour_slope_angle_sum.sv
// Contour slope-angle sum: points of a closed contour in, one sum per contour out.
// Channels: in_valid/in_ready carry one point (x, y, last_point) per item;
// out_valid/out_ready carry one result (angle_sum, undefined_term, point_count)
// per contour, issued after the item marked last_point.
// Timing: the first point of a contour is only captured. Each later point runs one
// CORDIC pass in a shared iterative unit, one rotation per cycle. The last point
// adds a second pass for the closing pair; the result register is then loaded.
// A single-point contour runs no pass and goes straight to the result register.
// The result sits in an output register; in_ready stays low only while a point
// is being worked on, or while a finished sum waits for a still-full result
// register when the receiver stalls.
// Reset (rst_n low, synchronous) clears the running sum, count and flags and
// drops out_valid; the block is ready for a new contour right after.
// Depends on csas_pkg, csas_ctrl and csas_dp.
`timescale 1ns / 1ps

module contour_slope_angle_sum import csas_pkg::*; #(
  parameter int MAX_POINTS      = MaxPointsDef,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  csas_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output csas_out_t out_data
);

  csas_cmd_t cmd;
  csas_sts_t sts;

  // Sequence the work
  csas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_point),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Compute and hold the sum
  csas_dp #(
    .MAX_POINTS      (MAX_POINTS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> rtl/csas_checker.sv
// Port-level checker for the contour slope-angle sum block, bound to the top.
// Depends on csas_pkg and contour_slope_angle_sum_defines.svh.
`timescale 1ns / 1ps
`include "contour_slope_angle_sum_defines.svh"

module csas_checker import csas_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input csas_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input csas_out_t out_data
);

  // A stalled result holds
  `CSAS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // The item that closes a contour keeps the input busy
  `CSAS_ASSERT_NXT(a_last_busy, clk, rst_n, in_valid && in_ready && in_data.last_point, !in_ready, "input ready right after last point")

  // A new result is loaded only while the input side is busy
  `CSAS_ASSERT_IMP(a_emit_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "result issued while idle")

  // A result always counts at least one point at the default size
  `CSAS_ASSERT_IMP(a_count_nz, clk, rst_n, out_valid && (MaxPointsDef < 8192), out_data.point_count != '0, "result with zero points")

endmodule

bind contour_slope_angle_sum csas_checker u_csas_checker (.*);
